>>> src/led_scanner_and_progress_bar_top_macros.svh
// Assertion macros shared by the RTL
`ifndef LED_SCANNER_AND_PROGRESS_BAR_TOP_MACROS_SVH
`define LED_SCANNER_AND_PROGRESS_BAR_TOP_MACROS_SVH

// same-cycle implication
`define LSPB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lspb_pkg.sv
`default_nettype none
package lspb_pkg;

    localparam int DEF_MAX_LEDS = 32;
    localparam int PROD_W       = 32;

    localparam logic [1:0] REG_LED_COUNT     = 2'd0;
    localparam logic [1:0] REG_SCAN_SPEED    = 2'd1;
    localparam logic [1:0] REG_DROPOFF_VALUE = 2'd2;
    localparam logic [1:0] REG_MAX_INTENSITY = 2'd3;

    localparam logic [5:0]  RST_LED_COUNT     = 6'd8;
    localparam logic [15:0] RST_SCAN_SPEED    = 16'd655;
    localparam logic [7:0]  RST_DROPOFF_VALUE = 8'd127;
    localparam logic [7:0]  RST_MAX_INTENSITY = 8'd255;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_LED,
        ST_DIV,
        ST_EMIT
    } lspb_state_t;

    typedef struct packed {
        logic accept_tick;
        logic accept_start;
        logic mul;
        logic upd;
        logic led;
        logic div;
        logic emit;
    } lspb_cmd_t;

    typedef struct packed {
        logic cd_tick;
        logic n_zero;
        logic div_needed;
        logic div_done;
        logic out_free;
        logic last;
    } lspb_status_t;

endpackage
`default_nettype wire

>>> src/led_scanner_and_progress_bar_top.sv
// Start transaction: taken in idle, no results.
// Scanner tick: multiply and update steps after acceptance, then per LED a level step
//   and an emit step that waits for a free output, on the shared per-LED datapath.
// Countdown tick: likewise, with the 1-bit-per-cycle divider before emit when needed.
// Reset (rst_n low, async): registers to defaults, scanner mode, head 0, forward.
`default_nettype none
module led_scanner_and_progress_bar_top #(
    parameter int MAX_LEDS = lspb_pkg::DEF_MAX_LEDS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [15:0] tick_ms,
    input  wire logic [23:0] duration_ms,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       led_index,
    output logic [7:0]       intensity,
    output logic             last_led
);
    import lspb_pkg::*;

    lspb_cmd_t    cmd;
    lspb_status_t status;

    lspb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lspb_dp #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .tick_ms     (tick_ms),
        .duration_ms (duration_ms),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .led_index   (led_index),
        .intensity   (intensity),
        .last_led    (last_led)
    );

endmodule
`default_nettype wire

>>> src/lspb_ctrl.sv
`default_nettype none
module lspb_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  command,
    output logic                       in_ready,
    input  wire lspb_pkg::lspb_status_t status,
    output lspb_pkg::lspb_cmd_t        cmd
);
    import lspb_pkg::*;
    `include "led_scanner_and_progress_bar_top_macros.svh"

    lspb_state_t state_reg, state_next;
    logic        accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_TICK)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                state_next = status.n_zero ? ST_IDLE : ST_LED;
            end
            ST_LED:
            begin
                state_next = (status.cd_tick && status.div_needed) ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.last ? ST_IDLE : ST_LED;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        cmd              = '0;
        cmd.accept_tick  = 1'b0;
        cmd.accept_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready         = 1'b1;
                cmd.accept_tick  = in_valid && command == CMD_TICK;
                cmd.accept_start = in_valid && command == CMD_START;
            end
            ST_MUL:  cmd.mul  = 1'b1;
            ST_UPD:  cmd.upd  = 1'b1;
            ST_LED:  cmd.led  = 1'b1;
            ST_DIV:  cmd.div  = 1'b1;
            ST_EMIT: cmd.emit = 1'b1;
            default: cmd      = '0;
        endcase
    end

    `LSPB_ASSERT_NEXT(a_tick_starts_mul, accept && command == CMD_TICK, state_reg == ST_MUL, "tick transaction did not start the multiply")
    `LSPB_ASSERT_NEXT(a_mul_to_upd, state_reg == ST_MUL, state_reg == ST_UPD, "multiply not followed by update")
    `LSPB_ASSERT_NEXT(a_div_done_emit, state_reg == ST_DIV && status.div_done, state_reg == ST_EMIT, "division end not followed by emit")

endmodule
`default_nettype wire

>>> src/lspb_dp.sv
`default_nettype none
module lspb_dp #(
    parameter int MAX_LEDS = lspb_pkg::DEF_MAX_LEDS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [15:0]           cfg_data,
    input  wire logic [15:0]           tick_ms,
    input  wire logic [23:0]           duration_ms,
    input  wire lspb_pkg::lspb_cmd_t   cmd,
    output lspb_pkg::lspb_status_t     status,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [4:0]                 led_index,
    output logic [7:0]                 intensity,
    output logic                       last_led
);
    import lspb_pkg::*;
    `include "led_scanner_and_progress_bar_top_macros.svh"

    localparam int NW = $clog2(MAX_LEDS + 1);
    localparam int IW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    logic [5:0]          led_count_reg;
    logic [15:0]         scan_speed_reg;
    logic [7:0]          dropoff_reg;
    logic [7:0]          max_int_reg;

    logic                mode_reg;
    logic signed [15:0]  head_reg;
    logic                dir_reg;
    logic [23:0]         total_reg;
    logic [23:0]         left_reg;

    logic [15:0]         dt_reg;
    logic                cd_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic signed [31:0]  d_reg;
    logic [IW-1:0]       idx_reg;
    logic [7:0]          level_reg;
    logic [24:0]         rem_reg;
    logic [7:0]          quo_reg;
    logic [2:0]          cnt_reg;

    logic                out_valid_reg;
    logic [4:0]          led_index_reg;
    logic [7:0]          intensity_reg;
    logic                last_reg;

    logic [NW-1:0]       n_w;
    logic [23:0]         left_c;
    logic [23:0]         elapsed;
    logic signed [26:0]  pos_raw;
    logic signed [26:0]  high_s;
    logic signed [17:0]  at_s;
    logic signed [17:0]  pos_s;
    logic signed [17:0]  edge_s;
    logic [17:0]         diff;
    logic [24:0]         drop_p;
    logic signed [25:0]  v_s;
    logic                dark;
    logic [7:0]          idle_level;
    logic                tot0;
    logic                d_pos;
    logic                d_ge;
    logic [24:0]         r_in;
    logic [24:0]         trial;
    logic                qbit;
    logic                load_out;

    assign n_w = ({1'b0, led_count_reg} > 7'(MAX_LEDS)) ? NW'(MAX_LEDS) : NW'(led_count_reg);
    assign left_c  = (left_reg > total_reg) ? total_reg : left_reg;
    assign elapsed = total_reg - left_c;

    assign high_s  = $signed({{(19 - NW){1'b0}}, n_w, 8'b0});
    assign pos_raw = dir_reg ? (27'(head_reg) + $signed({3'b0, prod_reg[31:8]}))
                             : (27'(head_reg) - $signed({3'b0, prod_reg[31:8]}));

    assign at_s   = $signed({{(10 - IW){1'b0}}, idx_reg, 8'b0});
    assign pos_s  = 18'(head_reg);
    assign edge_s = $signed({{(10 - NW){1'b0}}, NW'(n_w - NW'(1)), 8'b0});
    assign diff   = (pos_s > at_s) ? 18'(pos_s - at_s) : 18'(at_s - pos_s);
    assign drop_p = diff[16:0] * dropoff_reg;
    assign v_s    = $signed({10'b0, max_int_reg, 8'b0}) - $signed({1'b0, drop_p});
    assign dark   = (dir_reg && at_s > pos_s) || (!dir_reg && at_s < pos_s);

    always_comb
    begin
        if (dark || v_s <= 26'sd0)
        begin
            idle_level = 8'd0;
        end
        else
        begin
            idle_level = v_s[15:8];
        end
        if ((NW'(idx_reg) + NW'(1) == n_w && pos_s > edge_s) || (idx_reg == '0 && pos_s < 18'sd0))
        begin
            idle_level = max_int_reg;
        end
    end

    assign tot0  = (total_reg == 24'd0);
    assign d_pos = (d_reg > 32'sd0);
    assign d_ge  = (d_reg >= $signed({8'b0, total_reg}));

    assign r_in  = (cnt_reg == 3'd0) ? {1'b0, prod_reg[31:8]} : rem_reg;
    assign trial = {r_in[23:0], prod_reg[~cnt_reg]};
    assign qbit  = (trial >= {1'b0, total_reg});

    assign load_out = cmd.emit && status.out_free;

    assign status.cd_tick    = cd_reg;
    assign status.n_zero     = (n_w == '0);
    assign status.div_needed = !tot0 && d_pos && !d_ge;
    assign status.div_done   = (cnt_reg == 3'd7);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.last       = (NW'(idx_reg) + NW'(1) == n_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg  <= RST_LED_COUNT;
            scan_speed_reg <= RST_SCAN_SPEED;
            dropoff_reg    <= RST_DROPOFF_VALUE;
            max_int_reg    <= RST_MAX_INTENSITY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LED_COUNT:     led_count_reg  <= cfg_data[5:0];
                REG_SCAN_SPEED:    scan_speed_reg <= cfg_data;
                REG_DROPOFF_VALUE: dropoff_reg    <= cfg_data[7:0];
                REG_MAX_INTENSITY: max_int_reg    <= cfg_data[7:0];
                default:           led_count_reg  <= led_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            head_reg  <= '0;
            dir_reg   <= 1'b1;
            total_reg <= '0;
            left_reg  <= '0;
            cd_reg    <= 1'b0;
        end
        else if (cmd.accept_start)
        begin
            if (duration_ms == 24'd0)
            begin
                mode_reg <= 1'b0;
                head_reg <= '0;
                dir_reg  <= 1'b1;
            end
            else
            begin
                mode_reg  <= 1'b1;
                total_reg <= duration_ms;
                left_reg  <= duration_ms;
            end
        end
        else if (cmd.accept_tick)
        begin
            cd_reg <= mode_reg;
        end
        else if (cmd.upd)
        begin
            if (cd_reg)
            begin
                if (tot0 || left_reg <= 24'(dt_reg))
                begin
                    left_reg <= '0;
                    mode_reg <= 1'b0;
                    head_reg <= '0;
                    dir_reg  <= 1'b1;
                end
                else
                begin
                    left_reg <= left_reg - 24'(dt_reg);
                end
            end
            else if (pos_raw >= high_s)
            begin
                head_reg <= 16'(high_s);
                dir_reg  <= 1'b0;
            end
            else if (pos_raw <= -27'sd256)
            begin
                head_reg <= -16'sd256;
                dir_reg  <= 1'b1;
            end
            else
            begin
                head_reg <= 16'(pos_raw);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_tick)
        begin
            dt_reg <= tick_ms;
        end
        if (cmd.mul)
        begin
            if (cd_reg)
            begin
                prod_reg <= PROD_W'(elapsed * n_w);
            end
            else
            begin
                prod_reg <= PROD_W'(scan_speed_reg * dt_reg);
            end
        end
        else if (cmd.led && cd_reg)
        begin
            prod_reg <= PROD_W'(d_reg[23:0] * max_int_reg);
        end
        if (cmd.upd)
        begin
            d_reg   <= $signed(prod_reg);
            idx_reg <= '0;
        end
        else if (load_out && !status.last)
        begin
            d_reg   <= d_reg - $signed({8'b0, total_reg});
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.led)
        begin
            cnt_reg <= 3'd0;
            if (!cd_reg)
            begin
                level_reg <= idle_level;
            end
            else if (tot0 || !d_pos)
            begin
                level_reg <= 8'd0;
            end
            else
            begin
                level_reg <= max_int_reg;
            end
        end
        else if (cmd.div)
        begin
            rem_reg <= qbit ? (trial - {1'b0, total_reg}) : trial;
            quo_reg <= {quo_reg[6:0], qbit};
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                level_reg <= {quo_reg[6:0], qbit};
            end
        end
        if (load_out)
        begin
            led_index_reg <= 5'(idx_reg);
            intensity_reg <= level_reg;
            last_reg      <= status.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign led_index = led_index_reg;
    assign intensity = intensity_reg;
    assign last_led  = last_reg;

    `LSPB_ASSERT_IMPL(a_head_floor, 1'b1, head_reg >= -16'sd256, "head below the overscan floor")
    `LSPB_ASSERT_IMPL(a_rem_bound, cmd.div && cnt_reg != 3'd0, rem_reg < {1'b0, total_reg}, "division remainder out of range")

endmodule
`default_nettype wire

>>> test/led_scanner_and_progress_bar_top_tb.sv
`default_nettype none
module led_scanner_and_progress_bar_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lspb_pkg::*;

    localparam int  LIMIT_CYCLES = 3000000;
    localparam int  SETTLE       = 420;

    typedef struct packed {
        logic        cmd;
        logic [15:0] dt;
        logic [23:0] dur;
    } anim_req_t;

    typedef struct packed {
        logic [4:0] idx;
        logic [7:0] lvl;
        logic       last;
    } led_val_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [15:0] tick_ms;
    logic [23:0] duration_ms;
    logic        out_valid;
    logic        out_ready;
    logic [4:0]  led_index;
    logic [7:0]  intensity;
    logic        last_led;

    led_scanner_and_progress_bar_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .tick_ms     (tick_ms),
        .duration_ms (duration_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .led_index   (led_index),
        .intensity   (intensity),
        .last_led    (last_led)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    anim_req_t pending_reqs[$];
    led_val_t  expected_leds[$];
    int        err_cnt;
    int        cycle_cnt;
    int        in_acc_cnt;
    int        out_acc_cnt;
    int        max_in_gap;
    int        max_out_stall;

    // strip model
    logic [5:0]  m_led_count;
    logic [15:0] m_speed;
    logic [7:0]  m_drop;
    logic [7:0]  m_max;
    logic        m_countdown;
    longint      m_head;
    logic        m_fwd;
    longint      m_total;
    longint      m_left;

    task automatic report(input string what, input longint got, input longint want);
        err_cnt++;
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
    endtask

    task automatic push_led(input int i, input int n, input longint lv);
        led_val_t e;
        e.idx  = i[4:0];
        e.lvl  = lv[7:0];
        e.last = (i + 1 == n);
        expected_leds.push_back(e);
    endtask

    task automatic strip_go_idle();
        m_countdown = 1'b0;
        m_head      = 0;
        m_fwd       = 1'b1;
    endtask

    task automatic render_strip(input anim_req_t r);
        int     n;
        longint hi;
        longint inc;
        longint pos;
        longint at;
        longint diff;
        longint v;
        longint lv;
        longint lft;
        longint num;
        longint d;
        n = (m_led_count > 32) ? 32 : int'(m_led_count);
        if (r.cmd == CMD_START)
        begin
            if (r.dur == 0)
                strip_go_idle();
            else
            begin
                m_total     = r.dur;
                m_left      = r.dur;
                m_countdown = 1'b1;
            end
        end
        else if (m_countdown)
        begin
            lft = (m_left > m_total) ? m_total : m_left;
            num = (m_total - lft) * n;
            for (int i = 0; i < n; i++)
            begin
                at = longint'(i) * m_total;
                lv = 0;
                if (m_total != 0 && num > at)
                begin
                    d  = num - at;
                    lv = (d >= m_total) ? longint'(m_max) : (d * m_max) / m_total;
                end
                push_led(i, n, lv);
            end
            if (m_total == 0 || m_left <= r.dt)
            begin
                m_left = 0;
                strip_go_idle();
            end
            else
                m_left = m_left - r.dt;
        end
        else
        begin
            hi  = longint'(n) * 256;
            inc = (longint'(m_speed) * r.dt) >>> 8;
            pos = m_fwd ? m_head + inc : m_head - inc;
            if (pos >= hi)
            begin
                pos   = hi;
                m_fwd = 1'b0;
            end
            else if (pos <= -256)
            begin
                pos   = -256;
                m_fwd = 1'b1;
            end
            m_head = pos;
            for (int i = 0; i < n; i++)
            begin
                at = longint'(i) * 256;
                if ((m_fwd && at > pos) || (!m_fwd && at < pos))
                    lv = 0;
                else
                begin
                    diff = (pos > at) ? pos - at : at - pos;
                    v    = longint'(m_max) * 256 - diff * m_drop;
                    lv   = (v <= 0) ? 0 : v / 256;
                    if (lv > m_max)
                        lv = m_max;
                end
                if ((i + 1 == n && pos > longint'(n - 1) * 256) || (i == 0 && pos < 0))
                    lv = m_max;
                push_led(i, n, lv);
            end
        end
    endtask

    // accept and check
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("led_scanner_and_progress_bar_top_tb: errors");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                render_strip('{command, tick_ms, duration_ms});
                in_acc_cnt++;
            end
            if (out_valid && out_ready)
            begin
                out_acc_cnt++;
                if (expected_leds.size() == 0)
                    report("unexpected led_index", led_index, 0);
                else
                begin
                    if (led_index != expected_leds[0].idx)
                        report("led_index", led_index, expected_leds[0].idx);
                    if (intensity != expected_leds[0].lvl)
                        report("intensity", intensity, expected_leds[0].lvl);
                    if (last_led != expected_leds[0].last)
                        report("last_led", last_led, expected_leds[0].last);
                    void'(expected_leds.pop_front());
                end
            end
        end
    end

    // driver
    int        in_seen;
    int        in_gap;
    anim_req_t nxt;
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_acc_cnt != in_seen))
        begin
            if (in_acc_cnt != in_seen)
            begin
                in_seen = in_acc_cnt;
                in_gap  = $urandom_range(0, max_in_gap);
            end
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                nxt = pending_reqs.pop_front();
                in_valid    <= 1'b1;
                command     <= nxt.cmd;
                tick_ms     <= nxt.dt;
                duration_ms <= nxt.dur;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result sink
    int out_seen;
    int out_stall;
    always @(negedge clk)
    begin
        if (out_acc_cnt != out_seen)
        begin
            out_seen  = out_acc_cnt;
            out_stall = $urandom_range(0, max_out_stall);
        end
        if (out_stall > 0)
        begin
            out_stall--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic queue_req(input logic c, input logic [15:0] dt, input logic [23:0] dur);
        pending_reqs.push_back('{c, dt, dur});
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || expected_leds.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LED_COUNT:     m_led_count = val[5:0];
            REG_SCAN_SPEED:    m_speed     = val;
            REG_DROPOFF_VALUE: m_drop      = val[7:0];
            default:           m_max       = val[7:0];
        endcase
    endtask

    task automatic set_strip(input int n, input int spd, input int drp, input int mx);
        write_reg(REG_LED_COUNT, 16'(n));
        write_reg(REG_SCAN_SPEED, 16'(spd));
        write_reg(REG_DROPOFF_VALUE, 16'(drp));
        write_reg(REG_MAX_INTENSITY, 16'(mx));
    endtask

    task automatic random_chunk(input int cnt);
        int k;
        for (int j = 0; j < cnt; j++)
        begin
            k = $urandom_range(0, 19);
            if (k < 3)
                queue_req(CMD_START, 16'($urandom), 24'($urandom_range(1, 3000)));
            else if (k == 3)
                queue_req(CMD_START, 16'($urandom), 24'($urandom));
            else if (k == 4)
                queue_req(CMD_START, 16'($urandom), 24'd0);
            else if (k < 7)
                queue_req(CMD_TICK, 16'($urandom), 24'($urandom));
            else
                queue_req(CMD_TICK, 16'($urandom_range(0, 400)), 24'($urandom));
        end
    endtask

    task automatic random_phase();
        for (int c = 0; c < 3; c++)
        begin
            max_in_gap    = (c == 1) ? 0 : 11;
            max_out_stall = (c == 1) ? 0 : 11;
            random_chunk(30);
            drain();
        end
    endtask

    initial
    begin
        err_cnt       = 0;
        cycle_cnt     = 0;
        in_acc_cnt    = 0;
        out_acc_cnt   = 0;
        in_seen       = 0;
        out_seen      = 0;
        in_gap        = 0;
        out_stall     = 0;
        max_in_gap    = 11;
        max_out_stall = 11;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        command       = CMD_TICK;
        tick_ms       = '0;
        duration_ms   = '0;
        out_ready     = 1'b0;
        m_led_count   = RST_LED_COUNT;
        m_speed       = RST_SCAN_SPEED;
        m_drop        = RST_DROPOFF_VALUE;
        m_max         = RST_MAX_INTENSITY;
        m_total       = 0;
        m_left        = 0;
        strip_go_idle();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_req(CMD_TICK, 16'd0, 24'd0);
        queue_req(CMD_TICK, 16'd5, 24'hFFFFFF);
        queue_req(CMD_TICK, 16'hFFFF, 24'd0);
        queue_req(CMD_TICK, 16'd0, 24'd0);
        queue_req(CMD_TICK, 16'hFFFF, 24'd0);
        queue_req(CMD_START, 16'hFFFF, 24'd0);
        queue_req(CMD_TICK, 16'd1, 24'd0);
        queue_req(CMD_START, 16'd0, 24'd100);
        queue_req(CMD_TICK, 16'd0, 24'd0);
        queue_req(CMD_TICK, 16'd30, 24'd0);
        queue_req(CMD_TICK, 16'd33, 24'd0);
        queue_req(CMD_START, 16'd0, 24'd7);
        queue_req(CMD_TICK, 16'd3, 24'd0);
        queue_req(CMD_TICK, 16'd4, 24'd0);
        queue_req(CMD_TICK, 16'd1, 24'd0);
        queue_req(CMD_START, 16'd0, 24'hFFFFFF);
        queue_req(CMD_TICK, 16'hFFFF, 24'd0);
        queue_req(CMD_TICK, 16'hFFFF, 24'd0);
        queue_req(CMD_START, 16'd0, 24'd0);
        queue_req(CMD_TICK, 16'd0, 24'd0);
        drain();

        random_phase();
        set_strip(32, 65535, 255, 255);
        random_phase();
        set_strip(1, 0, 0, 0);
        random_phase();
        set_strip(63, $urandom_range(0, 4000), $urandom_range(0, 255), $urandom_range(0, 255));
        random_phase();
        set_strip($urandom_range(1, 32), $urandom, $urandom, $urandom);
        random_phase();

        write_reg(REG_LED_COUNT, 16'd0);
        queue_req(CMD_TICK, 16'd10, 24'd0);
        queue_req(CMD_START, 16'd0, 24'd50);
        queue_req(CMD_TICK, 16'd10, 24'd0);
        drain();
        write_reg(REG_LED_COUNT, 16'd5);
        queue_req(CMD_TICK, 16'd10, 24'd0);
        queue_req(CMD_TICK, 16'd60, 24'd0);
        drain();

        if (err_cnt == 0)
            $display("led_scanner_and_progress_bar_top_tb: clean");
        else
            $display("led_scanner_and_progress_bar_top_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+src
src/lspb_pkg.sv
src/lspb_ctrl.sv
src/lspb_dp.sv
src/led_scanner_and_progress_bar_top.sv
test/led_scanner_and_progress_bar_top_tb.sv
